[rtl/ffd_pkg.sv]
// Shared types, constants and helper functions of the fractional feedback delay.
`timescale 1ns / 1ps
`default_nettype none

package ffd_pkg;

	localparam int BUFFER_DEPTH = 131072;
	localparam int ADDR_W = $clog2(BUFFER_DEPTH);
	localparam int SAMPLE_WIDTH = 24;
	localparam int DIFF_W = SAMPLE_WIDTH + 1;
	localparam int IPROD_W = DIFF_W + 17;
	localparam int FBPROD_W = SAMPLE_WIDTH + 17;
	localparam int WETPROD_W = SAMPLE_WIDTH + 18;

	localparam int AUDIO_W = 24;
	localparam int MOD_W = 16;
	localparam int CFG_W = 20;
	localparam int IDX_W = 3;
	localparam int TARGET_W = 29;
	localparam int SMOOTH_W = 32;

	localparam logic [15:0] GAIN_SCALE = 16'd62259;
	localparam logic [19:0] CHORUS_SPAN = 20'd536871;
	localparam logic [TARGET_W-1:0] CHORUS_BASE = 29'd268435;
	localparam logic [16:0] UNITY = 17'd65536;

	localparam logic signed [63:0] SAMPLE_MAX = 64'sd2 ** (SAMPLE_WIDTH - 1) - 64'sd1;
	localparam logic signed [63:0] SAMPLE_MIN = -(64'sd2 ** (SAMPLE_WIDTH - 1));
	localparam logic signed [63:0] AUDIO_MAX = 64'sd2 ** (AUDIO_W - 1) - 64'sd1;
	localparam logic signed [63:0] AUDIO_MIN = -(64'sd2 ** (AUDIO_W - 1));

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [AUDIO_W-1:0] audio_t;
	typedef logic signed [MOD_W-1:0] mod_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [IDX_W-1:0] {
		REG_DELAY_TIME = 3'd0,
		REG_FEEDBACK = 3'd1,
		REG_WET_MIX = 3'd2,
		REG_MODE = 3'd3,
		REG_SAMPLE_RATE = 3'd4,
		REG_SMOOTH = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [19:0] delay_time;
		logic [15:0] feedback_knob;
		logic [16:0] wet_mix;
		logic mode;
		logic [17:0] sample_rate;
		logic [15:0] smooth_coeff;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TARGET,
		ST_STEP,
		ST_SMOOTH,
		ST_SCALE,
		ST_ACCESS,
		ST_INTERP,
		ST_BLEND,
		ST_MIX
	} state_t;

	function automatic sample_t sat_sample(input logic signed [63:0] v);
		sample_t r;
		if (v > SAMPLE_MAX) begin
			r = SAMPLE_WIDTH'(SAMPLE_MAX);
		end else if (v < SAMPLE_MIN) begin
			r = SAMPLE_WIDTH'(SAMPLE_MIN);
		end else begin
			r = SAMPLE_WIDTH'(v);
		end
		return r;
	endfunction

	function automatic audio_t sat_audio(input logic signed [63:0] v);
		audio_t r;
		if (v > AUDIO_MAX) begin
			r = AUDIO_W'(AUDIO_MAX);
		end else if (v < AUDIO_MIN) begin
			r = AUDIO_W'(AUDIO_MIN);
		end else begin
			r = AUDIO_W'(v);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/ffd_if.sv]
// Valid/ready channel interfaces for the input word and the result word.
`timescale 1ns / 1ps
`default_nettype none

interface ffd_in_if;
	import ffd_pkg::*;
	logic valid;
	logic ready;
	audio_t audio_in;
	mod_t mod_in;
	modport source (output valid, output audio_in, output mod_in, input ready);
	modport sink (input valid, input audio_in, input mod_in, output ready);
endinterface

interface ffd_out_if;
	import ffd_pkg::*;
	logic valid;
	logic ready;
	audio_t audio_out;
	modport source (output valid, output audio_out, input ready);
	modport sink (input valid, input audio_out, output ready);
endinterface

`default_nettype wire

[rtl/ffd_cfg.sv]
// Configuration register file written through the plain write port.
`timescale 1ns / 1ps
`default_nettype none

module ffd_cfg (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [ffd_pkg::IDX_W-1:0] wr_index,
	input logic [ffd_pkg::CFG_W-1:0] wr_data,
	output ffd_pkg::cfg_t cfg
);
	import ffd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_time <= '0;
			cfg_q.feedback_knob <= '0;
			cfg_q.wet_mix <= '0;
			cfg_q.mode <= 1'b0;
			cfg_q.sample_rate <= 18'd48000;
			cfg_q.smooth_coeff <= 16'd66;
		end else if (wr_en) begin
			case (wr_index)
				REG_DELAY_TIME: cfg_q.delay_time <= wr_data[19:0];
				REG_FEEDBACK: cfg_q.feedback_knob <= wr_data[15:0];
				REG_WET_MIX: cfg_q.wet_mix <= wr_data[16:0];
				REG_MODE: cfg_q.mode <= wr_data[0];
				REG_SAMPLE_RATE: cfg_q.sample_rate <= wr_data[17:0];
				REG_SMOOTH: cfg_q.smooth_coeff <= wr_data[15:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/ffd_store.sv]
// Delay sample memory: one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module ffd_store (
	input logic clk,
	input logic we,
	input ffd_pkg::addr_t waddr,
	input ffd_pkg::sample_t wdata,
	input logic re,
	input ffd_pkg::addr_t raddr_a,
	input ffd_pkg::addr_t raddr_b,
	output ffd_pkg::sample_t rdata_a,
	output ffd_pkg::sample_t rdata_b
);
	import ffd_pkg::*;

	sample_t store_q [BUFFER_DEPTH];
	sample_t rdata_a_q;
	sample_t rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a_q <= store_q[raddr_a];
			rdata_b_q <= store_q[raddr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

`default_nettype wire

[rtl/fractional_feedback_delay.sv]
// Top level: sequencer and datapath of the fractional feedback delay line.
// An accepted input word runs through the eight sequencer steps (target, step, smooth,
// scale, access, interp, blend, mix), each ending in a register after its multiplies or
// the sample memory access; the mix step holds while the output is stalled, and a new
// word is taken only in the idle step. Reset loads the register defaults, then clears
// all 131072 memory entries; configuration writes are taken then, input words are not.
`timescale 1ns / 1ps
`default_nettype none

module fractional_feedback_delay (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [ffd_pkg::IDX_W-1:0] wr_index,
	input logic [ffd_pkg::CFG_W-1:0] wr_data,
	ffd_in_if.sink in_ch,
	ffd_out_if.source out_ch
);
	import ffd_pkg::*;

	localparam addr_t ADDR_MAX = ADDR_W'(BUFFER_DEPTH - 1);

	cfg_t cfg;
	state_t state_q, state_d;
	addr_t clr_q;
	addr_t write_pos_q;
	logic [SMOOTH_W-1:0] smoothed_q;
	sample_t last_delayed_q;
	logic out_valid_q;
	audio_t out_q;

	audio_t x_q;
	mod_t m_q;
	logic [TARGET_W-1:0] target_q;
	logic [15:0] gain_q;
	logic signed [50:0] sprod_q;
	logic signed [FBPROD_W-1:0] fbprod_q;
	sample_t wr_q;
	logic [49:0] dprod_q;
	logic [15:0] t_q;
	logic signed [IPROD_W-1:0] iprod_q;
	logic signed [41:0] dryprod_q;
	logic signed [WETPROD_W-1:0] wetprod_q;

	logic [15:0] mod_off;
	logic [35:0] chorus_prod;
	logic [TARGET_W-1:0] target_c;
	logic [31:0] gain_prod;
	logic signed [33:0] diff;
	logic [15:0] frac;
	addr_t dint_lo;
	addr_t rd_pos;
	addr_t rd_prev;
	logic signed [DIFF_W-1:0] ydiff;
	logic [16:0] wet_c;
	logic [16:0] dry_c;
	sample_t delayed;
	logic mix_go;

	logic mem_we;
	addr_t mem_waddr;
	sample_t mem_wdata;
	logic mem_re;
	sample_t y0;
	sample_t y1;

	ffd_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.cfg(cfg)
	);

	ffd_store u_store (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr_a(rd_prev),
		.raddr_b(rd_pos),
		.rdata_a(y0),
		.rdata_b(y1)
	);

	always_comb begin
		mod_off = {~m_q[MOD_W-1], m_q[MOD_W-2:0]};
		chorus_prod = CHORUS_SPAN * mod_off;
		if (cfg.mode) begin
			target_c = CHORUS_BASE + TARGET_W'(chorus_prod[35:15]);
		end else begin
			target_c = {1'b0, cfg.delay_time, 8'd0};
		end
		gain_prod = cfg.feedback_knob * GAIN_SCALE;
		diff = signed'({5'd0, target_q}) - signed'({2'd0, smoothed_q});
		frac = dprod_q[27:12];
		dint_lo = dprod_q[28 + ADDR_W - 1:28];
		rd_pos = write_pos_q - dint_lo - ADDR_W'(|frac);
		rd_prev = rd_pos - ADDR_W'(1);
		ydiff = DIFF_W'(y1) - DIFF_W'(y0);
		wet_c = (cfg.wet_mix > UNITY) ? UNITY : cfg.wet_mix;
		dry_c = UNITY - wet_c;
		delayed = y0 + SAMPLE_WIDTH'(iprod_q >>> 16);
		mix_go = !out_valid_q || out_ch.ready;
	end

	always_comb begin
		state_d = state_q;
		mem_we = 1'b0;
		mem_waddr = write_pos_q;
		mem_wdata = wr_q;
		mem_re = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == ADDR_MAX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_ch.valid) begin
					state_d = ST_TARGET;
				end
			end
			ST_TARGET: state_d = ST_STEP;
			ST_STEP: state_d = ST_SMOOTH;
			ST_SMOOTH: state_d = ST_SCALE;
			ST_SCALE: state_d = ST_ACCESS;
			ST_ACCESS: begin
				mem_we = 1'b1;
				mem_re = 1'b1;
				state_d = ST_INTERP;
			end
			ST_INTERP: state_d = ST_BLEND;
			ST_BLEND: state_d = ST_MIX;
			ST_MIX: begin
				if (mix_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			write_pos_q <= '0;
			smoothed_q <= '0;
			last_delayed_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (state_q == ST_SMOOTH) begin
				smoothed_q <= smoothed_q + sprod_q[47:16];
			end
			if (state_q == ST_ACCESS) begin
				write_pos_q <= write_pos_q + ADDR_W'(1);
			end
			if (state_q == ST_BLEND) begin
				last_delayed_q <= delayed;
			end
			if (state_q == ST_MIX && mix_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q <= in_ch.audio_in;
				m_q <= in_ch.mod_in;
			end
			ST_TARGET: begin
				target_q <= target_c;
				gain_q <= gain_prod[31:16];
			end
			ST_STEP: begin
				sprod_q <= diff * signed'({1'b0, cfg.smooth_coeff});
				fbprod_q <= last_delayed_q * signed'({1'b0, gain_q});
			end
			ST_SMOOTH: begin
				wr_q <= sat_sample(64'(x_q) + 64'(fbprod_q >>> 16));
			end
			ST_SCALE: begin
				dprod_q <= smoothed_q * cfg.sample_rate;
			end
			ST_ACCESS: begin
				t_q <= ~frac + 16'd1;
			end
			ST_INTERP: begin
				iprod_q <= ydiff * signed'({1'b0, t_q});
				dryprod_q <= x_q * signed'({1'b0, dry_c});
			end
			ST_BLEND: begin
				wetprod_q <= delayed * signed'({1'b0, wet_c});
			end
			ST_MIX: begin
				if (mix_go) begin
					out_q <= sat_audio((64'(dryprod_q) + 64'(wetprod_q)) >>> 16);
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.audio_out = out_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> state_q == ST_TARGET)
		else $error("An accepted word did not start the sequence.");

	a_clear_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && clr_q == ADDR_MAX) |=> state_q == ST_IDLE)
		else $error("The clearing pass did not end after the last entry.");

	a_pos_advances: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ACCESS |=> write_pos_q == ADDR_W'($past(write_pos_q) + ADDR_W'(1)))
		else $error("The write position did not advance by one entry.");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_MIX))
		else $error("A result word appeared outside the mix step.");

endmodule

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the fractional feedback delay line with an internal line model.
`timescale 1ns / 1ps

module tb;
	import ffd_pkg::*;

	localparam int LINE_DEPTH = 131072;
	localparam longint PEAK_POS = 64'sd8388607;
	localparam longint PEAK_NEG = -64'sd8388608;
	localparam longint FB_SCALE_Q16 = 62259;
	localparam longint CHORUS_MIN_Q28 = 268435;
	localparam longint CHORUS_SPAN_Q28 = 536871;
	localparam longint UNITY_Q16 = 65536;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 800000;
	localparam int WORDS_PER_PHASE = 104;
	localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

	typedef struct {
		audio_t audio;
		mod_t mod;
	} stim_word_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [IDX_W-1:0] wr_index;
	logic [CFG_W-1:0] wr_data;

	ffd_in_if in_ch();
	ffd_out_if out_ch();

	fractional_feedback_delay dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	logic [19:0] cfg_delay;
	logic [15:0] cfg_knob;
	logic [16:0] cfg_wet;
	logic cfg_mode;
	logic [17:0] cfg_rate;
	logic [15:0] cfg_coeff;

	logic signed [23:0] line_mem [LINE_DEPTH];
	int unsigned line_wr_pos;
	logic [31:0] smoothed_q28;
	longint echo_prev;

	stim_word_t pending_words[$];
	audio_t expected_mix[$];
	int mismatches;
	int checked_words;
	int src_idle_pct;
	int snk_idle_pct;
	logic hold_req;
	int hold_left;
	int cycle_count;

	function automatic audio_t clip24(input longint v);
		if (v > PEAK_POS) begin
			return audio_t'(PEAK_POS);
		end else if (v < PEAK_NEG) begin
			return audio_t'(PEAK_NEG);
		end
		return audio_t'(v);
	endfunction

	// Advances the line model by one sample and returns the mixed output.
	function automatic audio_t delay_line_step(input audio_t x_in, input mod_t mod_val);
		longint x, target, diff, d, dint, frac, borrow, t, p, p0;
		longint y0, y1, echo, gain, fb, wet, dry;
		x = longint'(x_in);
		if (cfg_mode == 1'b0) begin
			target = longint'(cfg_delay) <<< 8;
		end else begin
			target = CHORUS_MIN_Q28 + ((CHORUS_SPAN_Q28 * (longint'(mod_val) + 32768)) >>> 15);
		end
		diff = target - longint'(smoothed_q28);
		smoothed_q28 = 32'(longint'(smoothed_q28) + ((longint'(cfg_coeff) * diff) >>> 16));

		d = (longint'(smoothed_q28) * longint'(cfg_rate)) >>> 12;
		dint = d >>> 16;
		frac = d & 64'hFFFF;
		borrow = (frac != 0) ? 1 : 0;
		t = (frac != 0) ? (UNITY_Q16 - frac) : 0;
		p = (longint'(line_wr_pos) + 2 * LINE_DEPTH - (dint % LINE_DEPTH) - borrow) % LINE_DEPTH;
		p0 = (p + LINE_DEPTH - 1) % LINE_DEPTH;
		y0 = longint'(line_mem[p0]);
		y1 = longint'(line_mem[p]);
		echo = y0 + ((t * (y1 - y0)) >>> 16);

		gain = (longint'(cfg_knob) * FB_SCALE_Q16) >>> 16;
		fb = x + ((echo_prev * gain) >>> 16);
		line_mem[line_wr_pos] = clip24(fb);
		echo_prev = echo;

		wet = (longint'(cfg_wet) > UNITY_Q16) ? UNITY_Q16 : longint'(cfg_wet);
		dry = UNITY_Q16 - wet;
		line_wr_pos = (line_wr_pos + 1) % LINE_DEPTH;
		return clip24((x * dry + echo * wet) >>> 16);
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40) begin
			$display("tb: %s", msg);
		end
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		case (idx)
			REG_DELAY_TIME: cfg_delay = val[19:0];
			REG_FEEDBACK: cfg_knob = val[15:0];
			REG_WET_MIX: cfg_wet = val[16:0];
			REG_MODE: cfg_mode = val[0];
			REG_SAMPLE_RATE: cfg_rate = val[17:0];
			REG_SMOOTH: cfg_coeff = val[15:0];
			default: ;
		endcase
	endtask

	task automatic close_writes();
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_regs(input logic [CFG_W-1:0] delay_v, input logic [CFG_W-1:0] knob_v,
			input logic [CFG_W-1:0] wet_v, input logic [CFG_W-1:0] mode_v,
			input logic [CFG_W-1:0] rate_v, input logic [CFG_W-1:0] coeff_v,
			input bit stray);
		write_reg(REG_DELAY_TIME, delay_v);
		write_reg(REG_FEEDBACK, knob_v);
		write_reg(REG_WET_MIX, wet_v);
		write_reg(REG_MODE, mode_v);
		write_reg(REG_SAMPLE_RATE, rate_v);
		write_reg(REG_SMOOTH, coeff_v);
		if (stray) begin
			write_reg(REG_SPARE_A, CFG_W'($urandom));
			write_reg(REG_SPARE_B, CFG_W'($urandom));
		end
		close_writes();
	endtask

	task automatic drain();
		while (pending_words.size() != 0 || in_ch.valid || expected_mix.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_word(input audio_t a, input mod_t m);
		stim_word_t w;
		w.audio = a;
		w.mod = m;
		pending_words.push_back(w);
	endtask

	task automatic queue_random(input int n);
		audio_t a;
		mod_t m;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: a = audio_t'(PEAK_POS);
				1: a = audio_t'(PEAK_NEG);
				2, 3: a = audio_t'(int'($urandom_range(8191)) - 4096);
				default: a = audio_t'($urandom);
			endcase
			case ($urandom_range(7))
				0: m = mod_t'(16'sh7FFF);
				1: m = mod_t'(16'sh8000);
				default: m = mod_t'($urandom);
			endcase
			queue_word(a, m);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin : drive_words
		logic busy;
		stim_word_t w;
		busy = in_ch.valid;
		if (in_ch.valid && in_ch.ready) begin
			expected_mix.push_back(delay_line_step(in_ch.audio_in, in_ch.mod_in));
			busy = 1'b0;
		end
		if (!busy) begin
			if (pending_words.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				w = pending_words.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.audio_in <= w.audio;
				in_ch.mod_in <= w.mod;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (hold_req) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin : check_words
		audio_t want;
		if (out_ch.valid && out_ch.ready) begin
			if (expected_mix.size() == 0) begin
				report_mismatch($sformatf("unexpected result word %0d", out_ch.audio_out));
			end else begin
				want = expected_mix.pop_front();
				if (out_ch.audio_out !== want) begin
					report_mismatch($sformatf("word %0d: audio_out %0d, expected %0d",
						checked_words, out_ch.audio_out, want));
				end
			end
			checked_words++;
		end
		out_ch.ready <= !hold_req && hold_left == 0 && $urandom_range(99) >= snk_idle_pct;
	end

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_ch.valid = 1'b0;
		in_ch.audio_in = '0;
		in_ch.mod_in = '0;
		out_ch.ready = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		cycle_count = 0;
		mismatches = 0;
		checked_words = 0;
		src_idle_pct = 15;
		snk_idle_pct = 66;
		cfg_delay = '0;
		cfg_knob = '0;
		cfg_wet = '0;
		cfg_mode = 1'b0;
		cfg_rate = 18'd48000;
		cfg_coeff = 16'd66;
		line_wr_pos = 0;
		smoothed_q28 = '0;
		echo_prev = 0;
		for (int i = 0; i < LINE_DEPTH; i++) begin
			line_mem[i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Short delay with full feedback, so echoes of full-scale words saturate the write.
		set_regs(20'd100, 20'd65535, 20'd32768, 20'd0, 20'd48000, 20'd65535, 1'b0);
		for (int i = 0; i < 4; i++) begin
			queue_word(audio_t'(PEAK_POS), mod_t'(16'sh7FFF));
		end
		for (int i = 0; i < 4; i++) begin
			queue_word(audio_t'(PEAK_NEG), mod_t'(16'sh8000));
		end
		queue_word('0, '0);
		queue_word(audio_t'(-1), mod_t'(-1));
		queue_word(audio_t'(1), mod_t'(1));
		queue_word(audio_t'(PEAK_POS), '0);
		drain();

		write_reg(REG_MODE, 20'd1);
		close_writes();
		queue_word(audio_t'(PEAK_POS), mod_t'(16'sh8000));
		queue_word(audio_t'(PEAK_NEG), mod_t'(16'sh7FFF));
		queue_word('0, '0);
		queue_word(audio_t'(-1), mod_t'(-1));
		queue_word(audio_t'(PEAK_POS), mod_t'(16'sh7FFF));
		queue_word(audio_t'(PEAK_NEG), mod_t'(16'sh8000));
		queue_word(audio_t'(1), mod_t'(1));
		queue_word(audio_t'(12345), mod_t'(16'sh4000));
		queue_word(audio_t'(-12345), mod_t'(16'shC000));
		queue_word(audio_t'(PEAK_POS), '0);
		drain();

		set_regs(20'd5000, 20'd40000, 20'd65536, 20'd0, 20'd48000, 20'd66, 1'b0);
		queue_random(WORDS_PER_PHASE);
		drain();

		// A delay of about one second runs past the end of the line and wraps.
		set_regs(20'hFFFFF, 20'd0, 20'd0, 20'd0, 20'd192000, 20'd65535, 1'b0);
		queue_random(WORDS_PER_PHASE);
		@(posedge clk);
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		drain();

		// Wet above unity is clamped.
		set_regs(20'd7000, 20'd65535, 20'h1FFFF, 20'd1, 20'd96000, 20'd30000, 1'b0);
		queue_random(WORDS_PER_PHASE);
		drain();

		src_idle_pct = 66;
		snk_idle_pct = 15;
		set_regs(20'd0, 20'd20000, 20'd49152, 20'd0, 20'd0, 20'd65535, 1'b0);
		queue_random(WORDS_PER_PHASE);
		drain();

		// Bits above each register's width are dropped; spare indexes are ignored.
		set_regs(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFE, 20'hFFFFF, 20'hF0042, 1'b1);
		queue_random(WORDS_PER_PHASE);
		drain();

		set_regs(20'd3000, 20'd1, 20'd1, 20'd1, 20'd8000, 20'd0, 1'b0);
		queue_random(WORDS_PER_PHASE);
		drain();

		src_idle_pct = 0;
		snk_idle_pct = 0;
		set_regs(20'd0, 20'd65535, 20'd65535, 20'd0, 20'd192000, 20'd65535, 1'b0);
		queue_random(WORDS_PER_PHASE);
		drain();

		set_regs(CFG_W'($urandom_range(30000)), CFG_W'($urandom_range(65535)),
			CFG_W'($urandom_range(65536)), CFG_W'($urandom_range(1)),
			CFG_W'($urandom_range(192000, 8000)), CFG_W'($urandom_range(65535)), 1'b0);
		queue_random(WORDS_PER_PHASE);
		drain();

		if (mismatches == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
